/* rtl/bsf_pkg.sv */
package bsf_pkg;

  // Grid limits, including the halo.
  localparam int unsigned MaxX = 64;
  localparam int unsigned MaxY = 64;
  localparam int unsigned MaxZ = 64;

  localparam int unsigned SampleBits = 32;

  localparam int unsigned XW = $clog2(MaxX);
  localparam int unsigned YW = $clog2(MaxY);
  localparam int unsigned ZW = $clog2(MaxZ);

  // Configuration port.
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned DimW    = 2;
  localparam int unsigned ExtW    = 7;

  // A column value carries weights summing to at most 16, the full sum 64.
  localparam int unsigned ColW = SampleBits + 4;
  localparam int unsigned SumW = SampleBits + 6;

  localparam int unsigned PlaneDepth = 2 ** (YW + XW);

  typedef enum logic [CfgIdxW-1:0] {
    CfgDimensions = 2'd0,
    CfgExtentX    = 2'd1,
    CfgExtentY    = 2'd2,
    CfgExtentZ    = 2'd3
  } cfg_idx_e;

  typedef logic signed [SampleBits-1:0] sample_t;

  // One column of the line store: the current plane and the two previous
  // planes, each one and two rows above the current row.
  typedef struct packed {
    sample_t cur1;
    sample_t cur2;
    sample_t pl1_1;
    sample_t pl1_2;
    sample_t pl2_1;
    sample_t pl2_2;
  } row_word_t;

  // One cell of the plane store: the same cell one and two planes back.
  typedef struct packed {
    sample_t pl1;
    sample_t pl2;
  } plane_word_t;

endpackage

/* rtl/bsf_ram.sv */
module bsf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data is registered and holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/binomial_stencil_filter_top.sv */
// Binomial [1,2,1]/4 smoothing filter over one padded grid field in 1, 2 or
// 3 dimensions, with 3, 9 or 27 taps.
//
// Samples enter on the input channel (in_valid_i, in_ready_o, sample_i) in
// raster order, x fastest, then y, then z. One result transaction leaves on
// the output channel (out_valid_o, out_ready_i, filtered_o, last_o) for each
// interior cell, on the arrival of the sample that completes its
// neighborhood; last_o marks the final interior cell of the frame.
// Samples and results are signed Q16.16; the weighted sum is exact and is
// rounded to nearest, ties toward plus infinity.
//
// One sample is accepted in every cycle while in_ready_o is high. A result
// follows the transaction of its completing sample through the store read
// stage, the column-sum stage and the output register. Samples keep coming
// while one result waits; once the column-sum stage holds a second one and
// the read stage is full, in_ready_o follows out_ready_i.
// Reset restores dimensions 3 and extents 64, clears the position and
// empties the pipeline; the line and plane stores are not cleared. Any
// configuration write restarts the frame at its first sample; the user must
// make writes only while the pipeline is empty, which the block does not enforce.
module binomial_stencil_filter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bsf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bsf_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [bsf_pkg::SampleBits-1:0] sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [bsf_pkg::SampleBits-1:0] filtered_o,
  output logic                            last_o
);

  localparam int unsigned RowW   = $bits(bsf_pkg::row_word_t);
  localparam int unsigned PlaneW = $bits(bsf_pkg::plane_word_t);
  localparam int unsigned ColW   = bsf_pkg::ColW;
  localparam int unsigned SumW   = bsf_pkg::SumW;
  localparam int unsigned ExtW   = bsf_pkg::ExtW;

  // Weighted sum a + 2b + c along one axis.
  function automatic logic signed [ColW-1:0] weigh3(
    input logic signed [ColW-1:0] a,
    input logic signed [ColW-1:0] b,
    input logic signed [ColW-1:0] c
  );
    return a + (b <<< 1) + c;
  endfunction

  // Saturate an extent into 3..hi.
  function automatic logic [ExtW-1:0] clamp_ext(
    input logic [ExtW-1:0] v,
    input int unsigned     hi
  );
    logic [ExtW-1:0] r;
    if (v < ExtW'(3)) begin
      r = ExtW'(3);
    end else if (32'(v) > hi) begin
      r = ExtW'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [bsf_pkg::DimW-1:0] dims_q;
  logic [ExtW-1:0]          ext_x_q, ext_y_q, ext_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= bsf_pkg::DimW'(3);
      ext_x_q <= ExtW'(64);
      ext_y_q <= ExtW'(64);
      ext_z_q <= ExtW'(64);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bsf_pkg::CfgDimensions: dims_q  <= cfg_data_i[bsf_pkg::DimW-1:0];
        bsf_pkg::CfgExtentX:    ext_x_q <= cfg_data_i[ExtW-1:0];
        bsf_pkg::CfgExtentY:    ext_y_q <= cfg_data_i[ExtW-1:0];
        bsf_pkg::CfgExtentZ:    ext_z_q <= cfg_data_i[ExtW-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings: dimension zero acts as one, and unused axes have
  // length one so that their position stays at zero.
  logic [bsf_pkg::DimW-1:0] dims;
  logic [ExtW-1:0]          ex, ey, ez;

  always_comb begin
    dims = (dims_q == '0) ? bsf_pkg::DimW'(1) : dims_q;
    ex   = clamp_ext(ext_x_q, bsf_pkg::MaxX);
    ey   = (dims >= bsf_pkg::DimW'(2)) ? clamp_ext(ext_y_q, bsf_pkg::MaxY) : ExtW'(1);
    ez   = (dims == bsf_pkg::DimW'(3)) ? clamp_ext(ext_z_q, bsf_pkg::MaxZ) : ExtW'(1);
  end

  // Pipeline handshakes. Stage one holds the store read data, stage two the
  // column sums, and the output register the finished result.
  logic v1_q, v2_q, out_valid_q;
  logic emit2_q;
  logic out_move, go2, go1, accept, adv1, load_out;

  assign out_move   = !out_valid_q || out_ready_i;
  assign go2        = !v2_q || !emit2_q || out_move;
  assign go1        = !v1_q || go2;
  assign in_ready_o = go1;
  assign accept     = in_valid_i && go1;
  assign adv1       = v1_q && go2;
  assign load_out   = v2_q && emit2_q && out_move;

  // Position of the next sample in the frame.
  logic [bsf_pkg::XW-1:0] pos_x_q, pos_x_d;
  logic [bsf_pkg::YW-1:0] pos_y_q, pos_y_d;
  logic [bsf_pkg::ZW-1:0] pos_z_q, pos_z_d;
  logic x_end, y_end, z_end;
  logic emit_now, last_now;

  always_comb begin
    x_end = (ExtW'(pos_x_q) == ex - ExtW'(1));
    y_end = (ExtW'(pos_y_q) == ey - ExtW'(1));
    z_end = (ExtW'(pos_z_q) == ez - ExtW'(1));

    // The cell one back on every filtered axis is complete with this sample.
    emit_now = (pos_x_q >= bsf_pkg::XW'(2))
            && ((dims < bsf_pkg::DimW'(2)) || (pos_y_q >= bsf_pkg::YW'(2)))
            && ((dims < bsf_pkg::DimW'(3)) || (pos_z_q >= bsf_pkg::ZW'(2)));
    last_now = x_end && y_end && z_end;

    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (x_end) begin
      pos_x_d = '0;
      if (y_end) begin
        pos_y_d = '0;
        pos_z_d = z_end ? '0 : pos_z_q + bsf_pkg::ZW'(1);
      end else begin
        pos_y_d = pos_y_q + bsf_pkg::YW'(1);
      end
    end else begin
      pos_x_d = pos_x_q + bsf_pkg::XW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (cfg_we_i) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (accept) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

  // Stage one: the sample and its position wait for the store reads, which
  // are issued in the cycle of the input transaction.
  bsf_pkg::sample_t        s1_sample_q;
  logic [bsf_pkg::XW-1:0]  s1_x_q;
  logic [bsf_pkg::YW-1:0]  s1_y_q;
  logic                    s1_emit_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (go1) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i;
      s1_x_q      <= pos_x_q;
      s1_y_q      <= pos_y_q;
      s1_emit_q   <= emit_now;
      s1_last_q   <= last_now;
    end
  end

  // The line store holds, per column, the rows above the current one; the
  // plane store holds, per cell, the two previous planes. Each is read at
  // the cell's own column and rewritten there when the sample leaves stage one,
  // shifted by one row or one plane, so neither needs a write-through path.
  logic [RowW-1:0]          row_rdata, row_wdata;
  logic [PlaneW-1:0]        plane_rdata, plane_wdata;
  bsf_pkg::row_word_t       row_rd, row_wr;
  bsf_pkg::plane_word_t     plane_rd, plane_wr;

  assign row_rd   = bsf_pkg::row_word_t'(row_rdata);
  assign plane_rd = bsf_pkg::plane_word_t'(plane_rdata);

  always_comb begin
    row_wr.cur1  = s1_sample_q;
    row_wr.cur2  = row_rd.cur1;
    row_wr.pl1_1 = plane_rd.pl1;
    row_wr.pl1_2 = row_rd.pl1_1;
    row_wr.pl2_1 = plane_rd.pl2;
    row_wr.pl2_2 = row_rd.pl2_1;
    plane_wr.pl1 = s1_sample_q;
    plane_wr.pl2 = plane_rd.pl1;
  end

  assign row_wdata   = RowW'(row_wr);
  assign plane_wdata = PlaneW'(plane_wr);

  bsf_ram #(
    .Width (RowW),
    .Depth (bsf_pkg::MaxX)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (s1_x_q),
    .wdata_i (row_wdata),
    .re_i    (accept),
    .raddr_i (pos_x_q),
    .rdata_o (row_rdata)
  );

  bsf_ram #(
    .Width (PlaneW),
    .Depth (bsf_pkg::PlaneDepth)
  ) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i ({s1_y_q, s1_x_q}),
    .wdata_i (plane_wdata),
    .re_i    (accept),
    .raddr_i ({pos_y_q, pos_x_q}),
    .rdata_o (plane_rdata)
  );

  // Column value: the filter along y and z at the current column.
  logic signed [ColW-1:0] a0, a1, a2, col;

  always_comb begin
    a0 = weigh3(ColW'(s1_sample_q), ColW'(row_rd.cur1), ColW'(row_rd.cur2));
    a1 = weigh3(ColW'(plane_rd.pl1), ColW'(row_rd.pl1_1), ColW'(row_rd.pl1_2));
    a2 = weigh3(ColW'(plane_rd.pl2), ColW'(row_rd.pl2_1), ColW'(row_rd.pl2_2));
    case (dims)
      bsf_pkg::DimW'(3): col = weigh3(a0, a1, a2);
      bsf_pkg::DimW'(2): col = a0;
      default:           col = ColW'(s1_sample_q);
    endcase
  end

  // Stage two: the last three column values, shifted once per sample, so
  // they line up with the sample now in this stage.
  logic signed [ColW-1:0] col0_q, col1_q, col2_q;
  logic                   last2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (go2) begin
      v2_q <= adv1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      col0_q  <= col;
      col1_q  <= col0_q;
      col2_q  <= col1_q;
      emit2_q <= s1_emit_q;
      last2_q <= s1_last_q;
    end
  end

  // Filter along x, then round: add half, shift right arithmetically.
  logic signed [SumW-1:0] total;
  logic signed [SumW:0]   half, biased, shifted;

  always_comb begin
    total  = SumW'(col0_q) + (SumW'(col1_q) <<< 1) + SumW'(col2_q);
    case (dims)
      bsf_pkg::DimW'(3): half = (SumW + 1)'(32);
      bsf_pkg::DimW'(2): half = (SumW + 1)'(8);
      default:           half = (SumW + 1)'(2);
    endcase
    biased = (SumW + 1)'(total) + half;
    case (dims)
      bsf_pkg::DimW'(3): shifted = biased >>> 6;
      bsf_pkg::DimW'(2): shifted = biased >>> 4;
      default:           shifted = biased >>> 2;
    endcase
  end

  // Output register.
  bsf_pkg::sample_t filtered_q;
  logic             last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_move) begin
      out_valid_q <= v2_q && emit2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      filtered_q <= shifted[bsf_pkg::SampleBits-1:0];
      last_q     <= last2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign last_o      = last_q;

endmodule

/* rtl/bsf_checker.sv */
module bsf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [bsf_pkg::SampleBits-1:0] filtered_o,
  input logic                            last_o
);

  // A result that is not taken stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o) && $stable(last_o))
    else $error("stalled result changed or dropped");

  // With room in the output register the filter never refuses a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("sample refused although the output can move");

  // Reset empties the pipeline at once.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

  // A result must pass the read stage, the column-sum stage and the output
  // register after its sample transaction, so none can appear just after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o ##1 !out_valid_o ##1 !out_valid_o)
    else $error("result appeared too soon after reset");

endmodule

bind binomial_stencil_filter_top bsf_checker u_bsf_checker (.*);

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsf_pkg::*;

  // Cycles without any transaction on either channel before the run is
  // declared hung. The slowest legal gap is a drain plus a full set of
  // register writes, so this limit is generous.
  localparam int unsigned StallLimit = 2000;

  // Cycles allowed after the last expected result before registers change.
  // The pipeline is three stages deep, so a sample that completes no cell
  // can still be in flight when the last result has arrived.
  localparam int unsigned DrainCycles = 8;

  // One expected smoothed cell.
  typedef struct {
    sample_t value;
    logic    last;
  } smoothed_cell_t;

  // The scoreboard carries its own copy of the filter state, the line and
  // plane stores included. Each accepted sample is run through the stencil
  // here, and any cell that it completes is queued for comparison.
  class stencil_scoreboard;
    int unsigned dims, ext_x, ext_y, ext_z;
    int unsigned px, py, pz;
    int plane_mem [2*MaxY*MaxX];
    int row_mem [2*MaxX];
    int prev_samples [2];
    smoothed_cell_t cells_q [$];
    int unsigned errors;

    function new();
      dims  = 3;
      ext_x = 64;
      ext_y = 64;
      ext_z = 64;
      px = 0;
      py = 0;
      pz = 0;
      errors = 0;
    endfunction

    static function int unsigned fit(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    // Any write restarts the frame; the stores keep their contents.
    function void write_reg(cfg_idx_e idx, logic [CfgW-1:0] data);
      case (idx)
        CfgDimensions: dims  = 32'(data[1:0]);
        CfgExtentX:    ext_x = 32'(data);
        CfgExtentY:    ext_y = 32'(data);
        CfgExtentZ:    ext_z = 32'(data);
        default: ;
      endcase
      px = 0;
      py = 0;
      pz = 0;
    endfunction

    function void note_sample(sample_t s);
      int unsigned d, ex, ey, ez, x, y, z;
      int unsigned dx, dy, dz, zmax, ymax, k, w;
      int unsigned xd, yd, zpar, ye, epar;
      int v;
      longint acc;
      logic [63:0] rounded;
      smoothed_cell_t res;

      d  = (dims == 0) ? 1 : dims;
      ex = fit(ext_x, MaxX);
      ey = (d >= 2) ? fit(ext_y, MaxY) : 1;
      ez = (d == 3) ? fit(ext_z, MaxZ) : 1;
      x = px;
      y = py;
      z = pz;
      if (x >= ex || y >= ey || z >= ez) begin
        x = 0;
        y = 0;
        z = 0;
      end

      if (x >= 2 && (d < 2 || y >= 2) && (d < 3 || z >= 2)) begin
        zmax = (d == 3) ? 2 : 0;
        ymax = (d >= 2) ? 2 : 0;
        k = 2 * d;
        acc = 0;
        for (dz = 0; dz <= zmax; dz++) begin
          for (dy = 0; dy <= ymax; dy++) begin
            for (dx = 0; dx < 3; dx++) begin
              if (dz == 0 && dy == 0)
                v = (dx == 0) ? int'(s) : prev_samples[dx-1];
              else if (dz == 0)
                v = row_mem[((y - dy) & 1) * MaxX + (x - dx)];
              else
                v = plane_mem[(((z - dz) & 1) * MaxY + (y - dy)) * MaxX + (x - dx)];
              w = ((dx == 1) ? 2 : 1) * ((dy == 1) ? 2 : 1) * ((dz == 1) ? 2 : 1);
              acc += longint'(v) * longint'(w);
            end
          end
        end
        // Round to nearest, ties toward plus infinity.
        rounded = (acc + (longint'(1) << (k - 1))) >>> k;
        res.value = rounded[SampleBits-1:0];
        res.last  = (x == ex - 1 && y == ey - 1 && z == ez - 1);
        cells_q.push_back(res);
      end

      if (d >= 2) begin
        // The sample two places back leaves the short history for the row store.
        if (x >= 2) begin
          xd = x - 2;
          yd = y;
          zpar = z & 1;
        end else if (y >= 1) begin
          xd = x + ex - 2;
          yd = y - 1;
          zpar = z & 1;
        end else begin
          xd = x + ex - 2;
          yd = ey - 1;
          zpar = (z + 1) & 1;
        end
        if (d == 3) begin
          // The row entry it displaces moves on to the plane store.
          if (yd >= 2) begin
            ye = yd - 2;
            epar = zpar;
          end else begin
            ye = ((((ey - 2) ^ yd) & 1) == 0) ? ey - 2 : ey - 1;
            epar = zpar ^ 1;
          end
          plane_mem[(epar * MaxY + ye) * MaxX + xd] = row_mem[(yd & 1) * MaxX + xd];
        end
        row_mem[(yd & 1) * MaxX + xd] = prev_samples[1];
      end
      prev_samples[1] = prev_samples[0];
      prev_samples[0] = s;

      x++;
      if (x >= ex) begin
        x = 0;
        y++;
        if (y >= ey) begin
          y = 0;
          z++;
          if (z >= ez) z = 0;
        end
      end
      px = x;
      py = y;
      pz = z;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(sample_t got, logic got_last);
      smoothed_cell_t exp_cell;
      if (cells_q.size() == 0) begin
        report($sformatf("result %h/%b with no cell pending", got, got_last));
      end else begin
        exp_cell = cells_q.pop_front();
        if (got !== exp_cell.value)
          report($sformatf("filtered %h, predicted %h", got, exp_cell.value));
        if (got_last !== exp_cell.last)
          report($sformatf("last %b, predicted %b", got_last, exp_cell.last));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  sample_t           sample_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  sample_t           filtered_o;
  logic              last_o;

  // While set, neither side inserts idle cycles.
  bit calm = 1'b0;
  int unsigned quiet_cycles = 0;

  stencil_scoreboard sb = new();

  binomial_stencil_filter_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .filtered_o (filtered_o),
    .last_o     (last_o)
  );

  always #6 clk_i = ~clk_i;

  // The result receiver stalls about 29 percent of the time, except
  // during the calm stretch.
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 29);
  end

  // Both monitors sample at the rising edge, before the block's flops
  // update, so they see the same handshake values the block does.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_sample(sample_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(filtered_o, last_o);
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offers one sample and returns once its transaction has happened. Valid
  // is left high; the next call either replaces the payload or idles at the
  // following falling edge, so a valid that stays high is never toggled.
  task automatic push_sample(input sample_t s);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stops the stream and waits until every predicted cell has come out and
  // the pipeline has had time to empty.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.cells_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Writes all four registers, starting at a random one, so the write that
  // restarts the frame last is not always the same register.
  task automatic apply_config(input logic [CfgW-1:0] d, input logic [CfgW-1:0] ex,
                              input logic [CfgW-1:0] ey, input logic [CfgW-1:0] ez);
    logic [CfgW-1:0] vals [4];
    int unsigned first;
    vals[0] = d;
    vals[1] = ex;
    vals[2] = ey;
    vals[3] = ez;
    first = $urandom_range(3);
    for (int i = 0; i < 4; i++) begin
      set_reg(cfg_idx_e'((first + i) % 4), vals[(first + i) % 4]);
    end
  endtask

  // Mostly tiny extents to keep frames short, with the saturating values
  // below 3 and above the maximum, and both limits, mixed in.
  function automatic logic [CfgW-1:0] draw_extent();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return CfgW'($urandom_range(4, 6));
    if (r < 72) return CfgW'(3);
    if (r < 85) return CfgW'(MaxX);
    if (r < 92) return CfgW'($urandom_range(0, 2));
    return CfgW'($urandom_range(MaxX + 1, 127));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned flen;
    int unsigned deff;
    logic [CfgW-1:0] d, ex, ey, ez;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // A couple of samples under the reset settings, a 64-cube in 3D. They
    // complete no cell.
    push_sample(32'sh7fff_ffff);
    push_sample(32'sh8000_0000);
    settle();

    // 1D over three cells: full-scale positive and negative rows, then
    // rounding ties on either side of zero.
    apply_config(1, 3, 3, 3);
    repeat (3) push_sample(32'sh7fff_ffff);
    repeat (3) push_sample(32'sh8000_0000);
    push_sample(1);
    push_sample(0);
    push_sample(1);
    push_sample(-1);
    push_sample(0);
    push_sample(-1);
    settle();

    // Zero dimensions behave as 1D, and an extent below 3 saturates to 3.
    apply_config(0, 0, 0, 0);
    push_sample(32'sh7fff_ffff);
    push_sample(32'sh8000_0000);
    push_sample(32'sh7fff_ffff);
    settle();

    // Smallest 2D frame: a single interior cell, which is also the last.
    apply_config(2, 3, 3, 3);
    push_sample(32'sh5555_5555);
    push_sample(32'shaaaa_aaaa);
    push_sample(32'sh7fff_ffff);
    push_sample(32'sh8000_0000);
    push_sample(32'sh0001_0000);
    push_sample(32'shffff_0000);
    push_sample(32'sh7fff_ffff);
    push_sample(32'sh8000_0000);
    push_sample(32'sh0000_0001);
    settle();

    // Random phases: whole frames, often several in a row so the position
    // wraps, and now and then a frame cut short by the next configuration.
    sent = 0;
    while (sent < 1200) begin
      calm = (sent >= 450 && sent < 750);
      d  = ($urandom_range(9) == 0) ? '0 : CfgW'($urandom_range(1, 3));
      ex = draw_extent();
      ey = draw_extent();
      ez = draw_extent();
      apply_config(d, ex, ey, ez);

      deff = (d == 0) ? 1 : 32'(d);
      flen = stencil_scoreboard::fit(32'(ex), MaxX);
      if (deff >= 2) flen = flen * stencil_scoreboard::fit(32'(ey), MaxY);
      if (deff == 3) flen = flen * stencil_scoreboard::fit(32'(ez), MaxZ);
      n = flen * $urandom_range(1, 3);
      if ($urandom_range(4) == 0) n = $urandom_range(1, flen);
      if (n > 250) n = 250;

      for (int i = 0; i < n; i++) begin
        push_sample($urandom);
      end
      sent += n;
      settle();
    end
    calm = 1'b0;

    if (sb.cells_q.size() != 0)
      sb.report($sformatf("%0d predicted cells never came out", sb.cells_q.size()));

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bsf_pkg.sv
rtl/bsf_ram.sv
rtl/binomial_stencil_filter_top.sv
rtl/bsf_checker.sv
sim/tb_top.sv
